// File: hdl/rtcq_pkg.sv
package rtcq_pkg;

    localparam int CH_W   = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int NPAL   = 16;
    localparam int IDX_W  = 4;
    localparam int NLVL   = 4;

    typedef enum logic [1:0] {
        KIND_TRUE    = 2'd0,
        KIND_XTERM   = 2'd1,
        KIND_CONSOLE = 2'd2
    } kind_t;

    localparam logic [1:0] CFG_ESCAPE     = 2'd0;
    localparam logic [1:0] CFG_TRUE_COLOR = 2'd1;

    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [IDX_W-1:0]  pidx_t;

    typedef struct packed {
        logic  esc;
        logic  tc;
        logic  bg;
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t xcode;
    } side_t;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    typedef struct packed {
        kind_t kind;
        chan_t code;
        chan_t r;
        chan_t g;
        chan_t b;
        logic  bg;
    } result_t;

    // per-channel palette levels
    localparam chan_t LVL_VAL [NLVL] = '{8'd0, 8'd128, 8'd192, 8'd255};

    // palette entry as level codes {r, g, b}
    localparam logic [5:0] PAL_LVL [NPAL] = '{
        6'b00_00_00, 6'b00_00_01, 6'b00_01_00, 6'b00_01_01,
        6'b01_00_00, 6'b01_00_01, 6'b01_01_00, 6'b10_10_10,
        6'b01_01_01, 6'b00_00_11, 6'b00_11_00, 6'b00_11_11,
        6'b11_00_00, 6'b11_00_11, 6'b11_11_00, 6'b11_11_11
    };

endpackage

// File: hdl/rtcq_sq.sv
module rtcq_sq (
    input  logic            aclk,
    input  logic            en,
    input  rtcq_pkg::side_t side_i,
    output rtcq_pkg::sq_t   sq_o [3][rtcq_pkg::NLVL],
    output rtcq_pkg::side_t side_o
);
    import rtcq_pkg::*;

    sq_t   sq_reg  [3][NLVL];
    sq_t   sq_next [3][NLVL];
    side_t side_reg;
    side_t side_next;

    function automatic logic [2:0] cube_lvl(input chan_t c);
        logic [2:0] v;
        if (c >= 8'd255) begin
            v = 3'd5;
        end else if (c >= 8'd204) begin
            v = 3'd4;
        end else if (c >= 8'd153) begin
            v = 3'd3;
        end else if (c >= 8'd102) begin
            v = 3'd2;
        end else if (c >= 8'd51) begin
            v = 3'd1;
        end else begin
            v = 3'd0;
        end
        return v;
    endfunction

    chan_t ch [3];
    assign ch[0] = side_i.r;
    assign ch[1] = side_i.g;
    assign ch[2] = side_i.b;

    always_comb begin
        chan_t d;
        for (int c = 0; c < 3; c++) begin
            for (int l = 0; l < NLVL; l++) begin
                d = (ch[c] >= LVL_VAL[l]) ? (ch[c] - LVL_VAL[l]) : (LVL_VAL[l] - ch[c]);
                sq_next[c][l] = SQ_W'(d) * SQ_W'(d);
            end
        end
    end

    logic [12:0] gray_prod;
    logic [4:0]  gray_q0;
    logic [8:0]  gray_rem;
    logic [4:0]  gray_q;
    chan_t       cube_code;

    always_comb begin
        // x/255 for x below 2^13: shift estimate, one correction
        gray_prod = 13'(side_i.r) * 13'd23;
        gray_q0   = gray_prod[12:8];
        gray_rem  = {1'b0, gray_prod[7:0]} + 9'(gray_q0);
        gray_q    = gray_q0 + 5'((gray_rem >= 9'd255) ? 1 : 0);
        cube_code = 8'd16 + 8'd36 * 8'(cube_lvl(side_i.r))
                  + 8'd6 * 8'(cube_lvl(side_i.g)) + 8'(cube_lvl(side_i.b));
        side_next = side_i;
        if ((side_i.r == side_i.g) && (side_i.g == side_i.b)) begin
            side_next.xcode = 8'd232 + 8'(gray_q);
        end else begin
            side_next.xcode = cube_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= sq_next;
            side_reg <= side_next;
        end
    end

    assign sq_o   = sq_reg;
    assign side_o = side_reg;

endmodule

// File: hdl/rtcq_argmin.sv
module rtcq_argmin (
    input  logic              aclk,
    input  rtcq_pkg::stage_en_t en,
    input  rtcq_pkg::sq_t     sq_i [3][rtcq_pkg::NLVL],
    input  rtcq_pkg::side_t   side_i,
    output rtcq_pkg::result_t res_o
);
    import rtcq_pkg::*;

    dist_t   dist_reg  [NPAL];
    dist_t   dist_next [NPAL];
    side_t   side3_reg;
    dist_t   best4_dist_reg  [4];
    dist_t   best4_dist_next [4];
    pidx_t   best4_idx_reg   [4];
    pidx_t   best4_idx_next  [4];
    side_t   side4_reg;
    result_t res_reg;
    result_t res_next;

    // palette distances
    always_comb begin
        for (int i = 0; i < NPAL; i++) begin
            dist_next[i] = DIST_W'(sq_i[0][PAL_LVL[i][5:4]])
                         + DIST_W'(sq_i[1][PAL_LVL[i][3:2]])
                         + DIST_W'(sq_i[2][PAL_LVL[i][1:0]]);
        end
    end

    // 16 to 4, lower index kept on ties
    always_comb begin
        dist_t d8 [8];
        pidx_t i8 [8];
        for (int j = 0; j < 8; j++) begin
            if (dist_reg[2*j+1] < dist_reg[2*j]) begin
                d8[j] = dist_reg[2*j+1];
                i8[j] = IDX_W'(2*j+1);
            end else begin
                d8[j] = dist_reg[2*j];
                i8[j] = IDX_W'(2*j);
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (d8[2*k+1] < d8[2*k]) begin
                best4_dist_next[k] = d8[2*k+1];
                best4_idx_next[k]  = i8[2*k+1];
            end else begin
                best4_dist_next[k] = d8[2*k];
                best4_idx_next[k]  = i8[2*k];
            end
        end
    end

    // 4 to 1 and result
    always_comb begin
        dist_t d2 [2];
        pidx_t i2 [2];
        pidx_t best;
        for (int k = 0; k < 2; k++) begin
            if (best4_dist_reg[2*k+1] < best4_dist_reg[2*k]) begin
                d2[k] = best4_dist_reg[2*k+1];
                i2[k] = best4_idx_reg[2*k+1];
            end else begin
                d2[k] = best4_dist_reg[2*k];
                i2[k] = best4_idx_reg[2*k];
            end
        end
        best = (d2[1] < d2[0]) ? i2[1] : i2[0];

        res_next.bg   = side4_reg.bg;
        res_next.kind = KIND_CONSOLE;
        res_next.code = '0;
        res_next.r    = '0;
        res_next.g    = '0;
        res_next.b    = '0;
        if (!side4_reg.esc) begin
            res_next.kind = KIND_CONSOLE;
            res_next.code = side4_reg.bg ? {best, 4'b0000} : {4'b0000, best};
        end else if (side4_reg.tc) begin
            res_next.kind = KIND_TRUE;
            res_next.r    = side4_reg.r;
            res_next.g    = side4_reg.g;
            res_next.b    = side4_reg.b;
        end else begin
            res_next.kind = KIND_XTERM;
            res_next.code = side4_reg.xcode;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            dist_reg  <= dist_next;
            side3_reg <= side_i;
        end
        if (en.s4) begin
            best4_dist_reg <= best4_dist_next;
            best4_idx_reg  <= best4_idx_next;
            side4_reg      <= side3_reg;
        end
        if (en.s5) begin
            res_reg <= res_next;
        end
    end

    assign res_o = res_reg;

endmodule

// File: hdl/rgb_terminal_color_quantizer_top.sv
// rgb to terminal color quantizer
// input stream: s_tdata carries red, green, blue; s_tuser carries the
// background flag. result stream: m_tdata carries color_code and the
// passed-through rgb, m_tuser carries out_kind and is_background.
// mode registers on the write port: index 0 escape_supported, index 1
// true_color_mode, both 1 after reset; write them only while no beat is
// in flight.
// one result beat per input beat. m_tvalid rises once the accepted beat has
// passed through five registers: input register, channel squares and
// xterm index, 16 palette distances, two levels of a compare tree, last
// two levels plus output select into the output register.
// throughput is one beat per cycle while m_tready stays high; every stage
// holds a valid bit and moves when the stage after it is empty or moving.
// when the receiver stalls, the pipe keeps filling until all five stages
// hold a beat, then s_tready drops; nothing is lost or repeated.
// reset (aresetn low, synchronous) empties the pipe and sets both mode
// registers to 1.
module rgb_terminal_color_quantizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic [0:0]  s_tuser,   // background
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // color_code, red_out, green_out, blue_out
    output logic [2:0]  m_tuser,   // out_kind, is_background
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [0:0]  cfg_wdata
);
    import rtcq_pkg::*;

    logic esc_reg;
    logic tc_reg;

    logic [5:1] v_reg;
    logic [5:1] v_next;
    logic [5:1] rdy;

    side_t     side1_reg;
    side_t     side2;
    sq_t       sq2 [3][NLVL];
    stage_en_t en;
    result_t   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg <= 1'b1;
            tc_reg  <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ESCAPE:     esc_reg <= cfg_wdata[0];
                CFG_TRUE_COLOR: tc_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rdy[5] = !v_reg[5] || m_tready;
        for (int k = 4; k >= 1; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[1] = rdy[1] ? s_tvalid : v_reg[1];
        for (int k = 2; k <= 5; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            side1_reg.esc   <= esc_reg;
            side1_reg.tc    <= tc_reg;
            side1_reg.bg    <= s_tuser[0];
            side1_reg.r     <= s_tdata[7:0];
            side1_reg.g     <= s_tdata[15:8];
            side1_reg.b     <= s_tdata[23:16];
            side1_reg.xcode <= '0;
        end
    end

    assign en.s3 = rdy[3];
    assign en.s4 = rdy[4];
    assign en.s5 = rdy[5];

    rtcq_sq u_sq (
        .aclk   (aclk),
        .en     (rdy[2]),
        .side_i (side1_reg),
        .sq_o   (sq2),
        .side_o (side2)
    );

    rtcq_argmin u_argmin (
        .aclk   (aclk),
        .en     (en),
        .sq_i   (sq2),
        .side_i (side2),
        .res_o  (res)
    );

    assign s_tready = rdy[1];
    assign m_tvalid = v_reg[5];
    assign m_tdata  = {res.b, res.g, res.r, res.code};
    assign m_tuser  = {res.bg, res.kind};

endmodule

// File: tb/tb.sv
module tb;
    import rtcq_pkg::*;

    localparam int          LIMIT_CYCLES    = 800000;
    localparam int          SETTLE_CYCLES   = 10;
    localparam int          PHASES          = 8;
    localparam int          PHASE_ITEMS     = 240;
    localparam logic [1:0]  CFG_UNMAPPED_LO = 2'd2;
    localparam logic [1:0]  CFG_UNMAPPED_HI = 2'd3;

    // console palette, {red, green, blue} per entry
    localparam logic [23:0] CONSOLE_PAL [16] = '{
        24'h000000, 24'h000080, 24'h008000, 24'h008080,
        24'h800000, 24'h800080, 24'h808000, 24'hc0c0c0,
        24'h808080, 24'h0000ff, 24'h00ff00, 24'h00ffff,
        24'hff0000, 24'hff00ff, 24'hffff00, 24'hffffff
    };

    // {escape_supported, true_color_mode} per phase
    localparam logic PHASE_MODE [PHASES][2] = '{
        '{1'b1, 1'b0}, '{1'b0, 1'b1}, '{1'b1, 1'b1}, '{1'b0, 1'b0},
        '{1'b1, 1'b0}, '{1'b0, 1'b0}, '{1'b1, 1'b1}, '{1'b0, 1'b1}
    };

    typedef struct packed {
        logic  esc;
        logic  tc;
        chan_t r;
        chan_t g;
        chan_t b;
        logic  bg;
        logic  typed;
        kind_t kind;
        chan_t code;
    } dir_row_t;

    localparam int NDIR = 21;
    localparam dir_row_t DIR_TAB [NDIR] = '{
        '{1'b1, 1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1, KIND_TRUE,    8'd0},
        '{1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, KIND_TRUE,    8'd0},
        '{1'b1, 1'b1, 8'h12,  8'h34,  8'h56,  1'b0, 1'b0, KIND_TRUE,    8'd0},
        '{1'b1, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1, KIND_XTERM,   8'd232},
        '{1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, KIND_XTERM,   8'd255},
        '{1'b1, 1'b0, 8'd255, 8'd0,   8'd0,   1'b0, 1'b1, KIND_XTERM,   8'd196},
        '{1'b1, 1'b0, 8'd0,   8'd0,   8'd255, 1'b1, 1'b1, KIND_XTERM,   8'd21},
        '{1'b1, 1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 1'b1, KIND_XTERM,   8'd46},
        '{1'b1, 1'b0, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, KIND_TRUE,    8'd0},
        '{1'b1, 1'b0, 8'd51,  8'd102, 8'd153, 1'b0, 1'b0, KIND_TRUE,    8'd0},
        '{1'b1, 1'b0, 8'd254, 8'd255, 8'd255, 1'b0, 1'b0, KIND_TRUE,    8'd0},
        '{1'b0, 1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1, KIND_CONSOLE, 8'd0},
        '{1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, KIND_CONSOLE, 8'hf0},
        '{1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, KIND_CONSOLE, 8'd15},
        '{1'b0, 1'b1, 8'd64,  8'd64,  8'd64,  1'b0, 1'b1, KIND_CONSOLE, 8'd0},
        '{1'b0, 1'b1, 8'd160, 8'd160, 8'd160, 1'b1, 1'b1, KIND_CONSOLE, 8'h70},
        '{1'b0, 1'b1, 8'd0,   8'd0,   8'd64,  1'b0, 1'b1, KIND_CONSOLE, 8'd0},
        '{1'b0, 1'b0, 8'd255, 8'd0,   8'd255, 1'b1, 1'b1, KIND_CONSOLE, 8'hd0},
        '{1'b0, 1'b0, 8'd0,   8'd128, 8'd128, 1'b0, 1'b1, KIND_CONSOLE, 8'd3},
        '{1'b0, 1'b0, 8'd200, 8'd30,  8'd90,  1'b1, 1'b0, KIND_TRUE,    8'd0},
        '{1'b1, 1'b1, 8'ha5,  8'h5a,  8'hc3,  1'b1, 1'b0, KIND_TRUE,    8'd0}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [0:0]  cfg_wdata = '0;

    logic        esc_mode  = 1'b1;
    logic        tc_mode   = 1'b1;
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    int          rx_hold   = 0;
    int          cycles    = 0;
    int          errors    = 0;
    int          kind_seen [3] = '{0, 0, 0};
    int          mode_changes = 0;
    result_t     awaited_colors [$];

    rgb_terminal_color_quantizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic result_t quantize_color(chan_t r, chan_t g, chan_t b, logic bg);
        result_t res;
        int      best;
        int      best_dist;
        int      sq_dist;
        int      dr;
        int      dg;
        int      db;
        res    = '0;
        res.bg = bg;
        if (esc_mode && tc_mode) begin
            res.kind = KIND_TRUE;
            res.r    = r;
            res.g    = g;
            res.b    = b;
        end else if (esc_mode) begin
            res.kind = KIND_XTERM;
            if (r == g && g == b)
                res.code = chan_t'(232 + (int'(r) * 23) / 255);
            else
                res.code = chan_t'(16 + 36 * ((int'(r) * 5) / 255)
                                   + 6 * ((int'(g) * 5) / 255) + (int'(b) * 5) / 255);
        end else begin
            res.kind  = KIND_CONSOLE;
            best      = 0;
            best_dist = 32'h7fffffff;
            for (int i = 0; i < 16; i++) begin
                dr      = int'(r) - int'(CONSOLE_PAL[i][23:16]);
                dg      = int'(g) - int'(CONSOLE_PAL[i][15:8]);
                db      = int'(b) - int'(CONSOLE_PAL[i][7:0]);
                sq_dist = dr * dr + dg * dg + db * db;
                if (sq_dist < best_dist) begin
                    best_dist = sq_dist;
                    best      = i;
                end
            end
            res.code = bg ? chan_t'(best << 4) : chan_t'(best);
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic chan_t pick_channel(int style);
        chan_t lvl [8] = '{8'd0, 8'd64, 8'd96, 8'd128, 8'd160, 8'd192, 8'd224, 8'd255};
        case (style)
            0:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            1:       return lvl[3'($urandom_range(0, 7))];
            2:       return chan_t'(51 * $urandom_range(0, 4) + ($urandom_range(0, 1) ? 50 : 0)
                                    + $urandom_range(0, 1));
            default: return chan_t'($urandom);
        endcase
    endfunction

    // random colors plus colors aimed at grays, cube edges and palette midpoints
    function automatic logic [23:0] pick_color();
        chan_t c;
        int    style;
        int    pick;
        pick  = $urandom_range(0, 9);
        style = (pick < 4) ? 3 : pick - 4;
        if (pick == 8 || pick == 9) begin
            c = chan_t'($urandom);
            if (pick == 8)
                return {c, c, c};
            return {c, c, chan_t'(c + ($urandom_range(0, 1) ? 8'd1 : 8'hff))};
        end
        return {pick_channel(style), pick_channel(style), pick_channel(style)};
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic queue_result(result_t r);
        awaited_colors = {awaited_colors, r};
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_steady || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            rx_hold  <= pick_gap();
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, awaited_colors.size());
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_colors.size() == 0) begin
                $display("%0t: unexpected result beat, got tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = awaited_colors.pop_front();
                check_field("out_kind", want.kind, m_tuser[1:0]);
                check_field("color_code", want.code, m_tdata[7:0]);
                check_field("red_out", want.r, m_tdata[15:8]);
                check_field("green_out", want.g, m_tdata[23:16]);
                check_field("blue_out", want.b, m_tdata[31:24]);
                check_field("is_background", want.bg, m_tuser[2]);
                if (want.kind <= KIND_CONSOLE)
                    kind_seen[want.kind]++;
            end
        end
    end

    task automatic send_color(logic [23:0] rgb, logic bg, int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            s_tuser  <= 1'($urandom);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
        s_tuser  <= bg;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_colors.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] addr, logic val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (addr == CFG_ESCAPE)
            esc_mode = val;
        else if (addr == CFG_TRUE_COLOR)
            tc_mode = val;
    endtask

    task automatic apply_mode(logic esc, logic tc);
        settle_idle();
        cfg_write(CFG_ESCAPE, esc);
        cfg_write(CFG_TRUE_COLOR, tc);
        // unmapped index must leave both modes alone
        cfg_write($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
                  1'($urandom_range(0, 1)));
        mode_changes++;
    endtask

    initial begin
        result_t     want;
        dir_row_t    row;
        logic [23:0] rgb;
        logic        bg;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NDIR; i++) begin
            row = DIR_TAB[i];
            if (row.esc != esc_mode || row.tc != tc_mode)
                apply_mode(row.esc, row.tc);
            send_color({row.r, row.g, row.b}, row.bg, pick_gap());
            if (row.typed) begin
                want      = '0;
                want.kind = row.kind;
                want.code = row.code;
                want.bg   = row.bg;
                if (row.kind == KIND_TRUE) begin
                    want.r = row.r;
                    want.g = row.g;
                    want.b = row.b;
                end
            end else begin
                want = quantize_color(row.r, row.g, row.b, row.bg);
            end
            queue_result(want);
        end

        for (int p = 0; p < PHASES; p++) begin
            apply_mode(PHASE_MODE[p][0], PHASE_MODE[p][1]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rgb = pick_color();
                bg  = 1'($urandom_range(0, 1));
                send_color(rgb, bg, tx_steady ? 0 : pick_gap());
                queue_result(quantize_color(rgb[23:16], rgb[15:8], rgb[7:0], bg));
            end
            rx_steady = 1'b0;
        end

        settle_idle();
        $display("results checked: %0d true color, %0d xterm index, %0d console palette",
                 kind_seen[KIND_TRUE], kind_seen[KIND_XTERM], kind_seen[KIND_CONSOLE]);
        $display("mode register settings applied: %0d, field mismatches: %0d",
                 mode_changes, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/rtcq_pkg.sv
hdl/rtcq_sq.sv
hdl/rtcq_argmin.sv
hdl/rgb_terminal_color_quantizer_top.sv
tb/tb.sv
